### src/lcdnb_pkg.sv
// shared types, constants and helpers for the character lcd nibble bus sequencer
package lcdnb_pkg;

    localparam int COUNT_WIDTH = 17;
    localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE_HIGH  = 3'd0,
        CFG_NIBBLE_GAP   = 3'd1,
        CFG_BYTE_SETTLE  = 3'd2,
        CFG_CLEAR_WAIT   = 3'd3,
        CFG_POWERUP_WAIT = 3'd4,
        CFG_INIT_GAP     = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_INIT  = 2'd2
    } t_req;

    typedef struct packed {
        logic [9:0]  enable_high_ticks;
        logic [9:0]  nibble_gap_ticks;
        logic [9:0]  byte_settle_ticks;
        logic [15:0] clear_wait_ticks;
        logic [16:0] powerup_wait_ticks;
        logic [9:0]  init_gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic [7:0] port_value;
        logic       busy_res;
        logic       accepted;
    } t_result;

    localparam logic [7:0] BIT_RS   = 8'h80;
    localparam logic [7:0] BIT_EN   = 8'h20;
    localparam logic [7:0] BIT_BL   = 8'h01;
    localparam logic [7:0] NIB_MASK = 8'h1E;

    localparam logic [7:0] CMD_CLEAR = 8'h01;

    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0: c = 8'h28;
            2'd1: c = 8'h06;
            2'd2: c = 8'h0E;
            default: c = CMD_CLEAR;
        endcase
        return c;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [16:0] v);
        logic [32:0] w;
        w = 33'(v);
        if (w > CNT_MAX) begin
            return CNT_MAX[COUNT_WIDTH-1:0];
        end
        return w[COUNT_WIDTH-1:0];
    endfunction

endpackage

### src/lcdnb_cfg.sv
// timing configuration registers
module lcdnb_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lcdnb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lcdnb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output lcdnb_pkg::t_cfg                     o_cfg
);

    lcdnb_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_high_ticks  <= 10'd10;
            r_cfg.nibble_gap_ticks   <= 10'd1;
            r_cfg.byte_settle_ticks  <= 10'd40;
            r_cfg.clear_wait_ticks   <= 16'd2000;
            r_cfg.powerup_wait_ticks <= 17'd100000;
            r_cfg.init_gap_ticks     <= 10'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lcdnb_pkg::CFG_ENABLE_HIGH:  r_cfg.enable_high_ticks  <= i_cfg_data[9:0];
                lcdnb_pkg::CFG_NIBBLE_GAP:   r_cfg.nibble_gap_ticks   <= i_cfg_data[9:0];
                lcdnb_pkg::CFG_BYTE_SETTLE:  r_cfg.byte_settle_ticks  <= i_cfg_data[9:0];
                lcdnb_pkg::CFG_CLEAR_WAIT:   r_cfg.clear_wait_ticks   <= i_cfg_data[15:0];
                lcdnb_pkg::CFG_POWERUP_WAIT: r_cfg.powerup_wait_ticks <= i_cfg_data[16:0];
                lcdnb_pkg::CFG_INIT_GAP:     r_cfg.init_gap_ticks     <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/lcdnb_core.sv
// sequencer state and the combinational step that applies one beat to it
module lcdnb_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [1:0]         i_req_type,
    input  logic [7:0]         i_byte_value,
    input  logic               i_reg_select,
    input  lcdnb_pkg::t_cfg    i_cfg,
    output lcdnb_pkg::t_result o_result
);

    typedef enum logic [8:0] {
        PH_IDLE       = 9'b000000001,
        PH_PWR_WAIT   = 9'b000000010,
        PH_INIT_EN    = 9'b000000100,
        PH_INIT_GAP   = 9'b000001000,
        PH_HI_EN      = 9'b000010000,
        PH_NIB_GAP    = 9'b000100000,
        PH_LO_EN      = 9'b001000000,
        PH_SETTLE     = 9'b010000000,
        PH_CLEAR_WAIT = 9'b100000000
    } t_phase;

    logic [7:0]                        r_port, n_port;
    t_phase                            r_phase, n_phase;
    logic [lcdnb_pkg::COUNT_WIDTH-1:0] r_count, n_count;
    logic [7:0]                        r_held_byte, n_held_byte;
    logic                              r_held_sel, n_held_sel;
    logic [3:0]                        r_init_step, n_init_step;
    logic                              acc;

    logic       fin_more;
    logic [3:0] fin_step;
    logic [1:0] cmd_idx;
    logic [7:0] fin_byte;
    logic [3:0] gap_step;

    function automatic logic [7:0] nib_bits(input logic [3:0] n);
        return {3'b000, n[0], n[1], n[2], n[3], 1'b0};
    endfunction

    function automatic logic [7:0] begin_port(input logic [7:0] port, input logic [7:0] b,
                                              input logic sel);
        logic [7:0] p;
        p = (port & ~lcdnb_pkg::NIB_MASK) | lcdnb_pkg::BIT_EN | nib_bits(b[7:4]);
        p[7] = sel;
        return p;
    endfunction

    assign fin_more = (r_init_step >= 4'd5) && (r_init_step < 4'd8);
    assign fin_step = r_init_step + 4'd1;
    assign cmd_idx  = fin_step[1:0] - 2'd1;
    assign fin_byte = lcdnb_pkg::init_cmd(cmd_idx);
    assign gap_step = r_init_step + 4'd1;

    always_comb begin
        n_port      = r_port;
        n_phase     = r_phase;
        n_count     = r_count;
        n_held_byte = r_held_byte;
        n_held_sel  = r_held_sel;
        n_init_step = r_init_step;
        acc         = 1'b0;

        case (i_req_type)
            lcdnb_pkg::REQ_TICK: begin
                acc = 1'b1;
                if (r_phase != PH_IDLE) begin
                    if (r_count > lcdnb_pkg::COUNT_WIDTH'(1)) begin
                        n_count = r_count - lcdnb_pkg::COUNT_WIDTH'(1);
                    end else begin
                        case (r_phase)
                            PH_PWR_WAIT: begin
                                n_port      = lcdnb_pkg::BIT_BL | lcdnb_pkg::BIT_EN
                                              | nib_bits(4'h3);
                                n_init_step = 4'd1;
                                n_phase     = PH_INIT_EN;
                                n_count     = lcdnb_pkg::sat_count(
                                                  17'(i_cfg.enable_high_ticks));
                            end
                            PH_INIT_EN: begin
                                if (r_init_step < 4'd4) begin
                                    n_port  = r_port & ~lcdnb_pkg::BIT_EN;
                                    n_phase = PH_INIT_GAP;
                                    n_count = lcdnb_pkg::sat_count(17'(i_cfg.init_gap_ticks));
                                end else begin
                                    // first init command starts right away
                                    n_init_step = 4'd5;
                                    n_held_byte = lcdnb_pkg::init_cmd(2'd0);
                                    n_held_sel  = 1'b0;
                                    n_port      = begin_port(r_port, lcdnb_pkg::init_cmd(2'd0),
                                                             1'b0);
                                    n_phase     = PH_HI_EN;
                                    n_count     = lcdnb_pkg::sat_count(
                                                      17'(i_cfg.enable_high_ticks));
                                end
                            end
                            PH_INIT_GAP: begin
                                n_init_step = gap_step;
                                n_port      = (r_port & ~lcdnb_pkg::NIB_MASK) | lcdnb_pkg::BIT_EN
                                              | nib_bits((gap_step >= 4'd4) ? 4'h2 : 4'h3);
                                n_phase     = PH_INIT_EN;
                                n_count     = lcdnb_pkg::sat_count(
                                                  17'(i_cfg.enable_high_ticks));
                            end
                            PH_HI_EN: begin
                                n_port  = r_port & ~lcdnb_pkg::BIT_EN;
                                n_phase = PH_NIB_GAP;
                                n_count = lcdnb_pkg::sat_count(17'(i_cfg.nibble_gap_ticks));
                            end
                            PH_NIB_GAP: begin
                                n_port  = (r_port & ~lcdnb_pkg::NIB_MASK) | lcdnb_pkg::BIT_EN
                                          | nib_bits(r_held_byte[3:0]);
                                n_phase = PH_LO_EN;
                                n_count = lcdnb_pkg::sat_count(17'(i_cfg.enable_high_ticks));
                            end
                            PH_LO_EN: begin
                                n_port  = r_port & ~lcdnb_pkg::BIT_EN;
                                n_phase = PH_SETTLE;
                                n_count = lcdnb_pkg::sat_count(17'(i_cfg.byte_settle_ticks));
                            end
                            PH_SETTLE, PH_CLEAR_WAIT: begin
                                if (r_phase == PH_SETTLE && !r_held_sel) begin
                                    n_port = r_port | lcdnb_pkg::BIT_RS;
                                end
                                if (r_phase == PH_SETTLE && !r_held_sel
                                    && r_held_byte == lcdnb_pkg::CMD_CLEAR) begin
                                    n_phase = PH_CLEAR_WAIT;
                                    n_count = lcdnb_pkg::sat_count(
                                                  17'(i_cfg.clear_wait_ticks));
                                end else if (fin_more) begin
                                    // next init command
                                    n_init_step = fin_step;
                                    n_held_byte = fin_byte;
                                    n_held_sel  = 1'b0;
                                    n_port      = begin_port(r_port, fin_byte, 1'b0);
                                    n_phase     = PH_HI_EN;
                                    n_count     = lcdnb_pkg::sat_count(
                                                      17'(i_cfg.enable_high_ticks));
                                end else begin
                                    n_init_step = 4'd0;
                                    n_phase     = PH_IDLE;
                                    n_count     = '0;
                                end
                            end
                            default: begin
                                n_phase     = PH_IDLE;
                                n_count     = '0;
                                n_init_step = 4'd0;
                            end
                        endcase
                    end
                end
            end
            lcdnb_pkg::REQ_WRITE: begin
                if (r_phase == PH_IDLE) begin
                    acc         = 1'b1;
                    n_held_byte = i_byte_value;
                    n_held_sel  = i_reg_select;
                    n_init_step = 4'd0;
                    n_port      = begin_port(r_port, i_byte_value, i_reg_select);
                    n_phase     = PH_HI_EN;
                    n_count     = lcdnb_pkg::sat_count(17'(i_cfg.enable_high_ticks));
                end
            end
            lcdnb_pkg::REQ_INIT: begin
                if (r_phase == PH_IDLE) begin
                    acc         = 1'b1;
                    n_port      = 8'h00;
                    n_init_step = 4'd0;
                    n_phase     = PH_PWR_WAIT;
                    n_count     = lcdnb_pkg::sat_count(i_cfg.powerup_wait_ticks);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port      <= 8'h00;
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_held_byte <= 8'h00;
            r_held_sel  <= 1'b0;
            r_init_step <= 4'd0;
        end else if (i_step) begin
            r_port      <= n_port;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_held_byte <= n_held_byte;
            r_held_sel  <= n_held_sel;
            r_init_step <= n_init_step;
        end
    end

    assign o_result.port_value = n_port;
    assign o_result.busy_res   = (n_phase != PH_IDLE);
    assign o_result.accepted   = acc;

endmodule

### src/char_lcd_nibble_bus_sequencer.sv
// top level: input register, sequencer step, result register and config port
//
// usage: each input beat is a one-microsecond tick, a byte write or an init
// request; each beat yields exactly one result beat carrying the lcd port
// image after that beat, the busy flag and whether the request was taken.
// requests that arrive while a sequence or wait runs come back refused;
// ticks are always taken and count the running phase down.
// a beat accepted into the input register is stepped into the result register
// once that register is free; its result is valid on the output from then on.
// throughput: one beat per cycle while i_ready is high; the step is one compare,
// one decrement and a phase update between the input and result registers.
// stall: when the receiver holds i_ready low the result register keeps its
// beat, one more beat waits in the input register, then o_ready drops.
// reset: synchronous, active low; timing registers return to defaults,
// port image, phase and counters clear, both beat registers empty.
// configuration writes take effect at the next edge; they are to be made only
// while the block is idle, a rule on the user that the block leaves unchecked.
module char_lcd_nibble_bus_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_req_type,
    input  logic [7:0]                       i_byte_value,
    input  logic                             i_reg_select,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [7:0]                       o_port_value,
    output logic                             o_busy_res,
    output logic                             o_accepted,
    input  logic                             i_cfg_we,
    input  logic [lcdnb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lcdnb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic               r_in_valid;
    logic [1:0]         r_req_type;
    logic [7:0]         r_byte_value;
    logic               r_reg_select;
    logic               r_out_valid;
    lcdnb_pkg::t_result r_out;
    lcdnb_pkg::t_result step_res;
    lcdnb_pkg::t_cfg    cfg;
    logic               out_free;
    logic               step;
    logic               in_fire;

    assign out_free = !r_out_valid || i_ready;
    assign step     = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;
    assign in_fire  = i_valid && o_ready;

    lcdnb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lcdnb_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_req_type   (r_req_type),
        .i_byte_value (r_byte_value),
        .i_reg_select (r_reg_select),
        .i_cfg        (cfg),
        .o_result     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_fire || (r_in_valid && !step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req_type   <= i_req_type;
            r_byte_value <= i_byte_value;
            r_reg_select <= i_reg_select;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= step || (r_out_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_port_value = r_out.port_value;
    assign o_busy_res   = r_out.busy_res;
    assign o_accepted   = r_out.accepted;

`ifndef ASSERT_OFF
    // a registered beat with room downstream must come out next cycle
    a_step_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && out_free |=> o_valid)
        else $error("registered beat did not reach the output");

    // a taken input beat is held in the input register
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_in_valid)
        else $error("input beat lost");

    // when idle the enable line is low
    a_idle_en_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_busy_res |-> !o_port_value[5])
        else $error("enable high while idle");

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_out))
        else $error("result beat changed while stalled");
`endif

endmodule

### verif/lcdnb_checker.sv
// result checker for the lcd nibble bus sequencer: predicts every result beat and compares
`timescale 1ns / 100ps
module lcdnb_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [1:0]                       i_req_type,
    input  logic [7:0]                       i_byte_value,
    input  logic                             i_reg_select,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [7:0]                       i_port_value,
    input  logic                             i_busy_res,
    input  logic                             i_accepted,
    input  logic                             i_cfg_we,
    input  logic [lcdnb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lcdnb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                               o_mismatches,
    output int                               o_outstanding,
    output logic                             o_seq_busy
);
    import lcdnb_pkg::*;

    typedef enum logic [4:0] {
        SEQ_IDLE,
        SEQ_PWR_WAIT,
        SEQ_INIT_EN,
        SEQ_INIT_GAP,
        SEQ_HI_EN,
        SEQ_NIB_GAP,
        SEQ_LO_EN,
        SEQ_SETTLE,
        SEQ_CLEAR_WAIT
    } t_seq_phase;

    localparam logic [7:0]  RS_BIT      = 8'h80;
    localparam logic [7:0]  EN_BIT      = 8'h20;
    localparam logic [7:0]  BL_BIT      = 8'h01;
    localparam logic [7:0]  NIBBLE_BITS = 8'h1E;
    localparam logic [7:0]  CLEAR_CMD   = 8'h01;
    localparam logic [31:0] INIT_CMDS   = {8'h01, 8'h0E, 8'h06, 8'h28};
    localparam logic [63:0] COUNT_CAP   = (64'd1 << COUNT_WIDTH) - 64'd1;

    t_cfg        timing;
    logic [7:0]  lcd_port;
    t_seq_phase  seq;
    logic [63:0] remaining;
    logic [7:0]  held_byte;
    logic        held_sel;
    logic [3:0]  init_step;
    t_result     port_image_q[$];
    int          mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic logic [7:0] nibble_on_port(logic [3:0] n);
        return {3'b000, n[0], n[1], n[2], n[3], 1'b0};
    endfunction

    function automatic void load_phase(t_seq_phase nxt, logic [63:0] ticks);
        seq = nxt;
        remaining = (ticks > COUNT_CAP) ? COUNT_CAP : ticks;
    endfunction

    function automatic void drive_high_nibble();
        logic [7:0] p;
        p = (lcd_port & ~NIBBLE_BITS) | EN_BIT | nibble_on_port(held_byte[7:4]);
        p[7] = held_sel;
        lcd_port = p;
        load_phase(SEQ_HI_EN, 64'(timing.enable_high_ticks));
    endfunction

    function automatic void close_byte();
        if (init_step >= 4'd5 && init_step < 4'd8) begin
            init_step = init_step + 4'd1;
            held_byte = INIT_CMDS[8 * (init_step - 4'd5) +: 8];
            held_sel = 1'b0;
            drive_high_nibble();
        end else begin
            init_step = 4'd0;
            seq = SEQ_IDLE;
            remaining = 64'd0;
        end
    endfunction

    function automatic void expire_phase();
        case (seq)
            SEQ_PWR_WAIT: begin
                lcd_port = BL_BIT | EN_BIT | nibble_on_port(4'h3);
                init_step = 4'd1;
                load_phase(SEQ_INIT_EN, 64'(timing.enable_high_ticks));
            end
            SEQ_INIT_EN: begin
                lcd_port = lcd_port & ~EN_BIT;
                if (init_step < 4'd4) begin
                    load_phase(SEQ_INIT_GAP, 64'(timing.init_gap_ticks));
                end else begin
                    init_step = 4'd5;
                    held_byte = INIT_CMDS[7:0];
                    held_sel = 1'b0;
                    drive_high_nibble();
                end
            end
            SEQ_INIT_GAP: begin
                init_step = init_step + 4'd1;
                lcd_port = (lcd_port & ~NIBBLE_BITS) | EN_BIT
                         | nibble_on_port((init_step >= 4'd4) ? 4'h2 : 4'h3);
                load_phase(SEQ_INIT_EN, 64'(timing.enable_high_ticks));
            end
            SEQ_HI_EN: begin
                lcd_port = lcd_port & ~EN_BIT;
                load_phase(SEQ_NIB_GAP, 64'(timing.nibble_gap_ticks));
            end
            SEQ_NIB_GAP: begin
                lcd_port = (lcd_port & ~NIBBLE_BITS) | EN_BIT | nibble_on_port(held_byte[3:0]);
                load_phase(SEQ_LO_EN, 64'(timing.enable_high_ticks));
            end
            SEQ_LO_EN: begin
                lcd_port = lcd_port & ~EN_BIT;
                load_phase(SEQ_SETTLE, 64'(timing.byte_settle_ticks));
            end
            SEQ_SETTLE: begin
                // commands hand RS back high; a clear command adds its own wait
                if (!held_sel) lcd_port = lcd_port | RS_BIT;
                if (!held_sel && held_byte == CLEAR_CMD) begin
                    load_phase(SEQ_CLEAR_WAIT, 64'(timing.clear_wait_ticks));
                end else begin
                    close_byte();
                end
            end
            SEQ_CLEAR_WAIT: begin
                close_byte();
            end
            default: begin
                seq = SEQ_IDLE;
                remaining = 64'd0;
                init_step = 4'd0;
            end
        endcase
    endfunction

    function automatic t_result advance_sequencer(logic [1:0] kind, logic [7:0] value,
                                                  logic sel);
        t_result r;
        logic    taken;
        taken = 1'b0;
        case (kind)
            REQ_TICK: begin
                taken = 1'b1;
                if (seq != SEQ_IDLE) begin
                    if (remaining > 64'd1) remaining = remaining - 64'd1;
                    else expire_phase();
                end
            end
            REQ_WRITE, REQ_INIT: begin
                if (seq == SEQ_IDLE) begin
                    taken = 1'b1;
                    init_step = 4'd0;
                    if (kind == REQ_WRITE) begin
                        held_byte = value;
                        held_sel = sel;
                        drive_high_nibble();
                    end else begin
                        lcd_port = 8'h00;
                        load_phase(SEQ_PWR_WAIT, 64'(timing.powerup_wait_ticks));
                    end
                end
            end
            default: ;
        endcase
        r.port_value = lcd_port;
        r.busy_res = (seq != SEQ_IDLE);
        r.accepted = taken;
        return r;
    endfunction

    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ENABLE_HIGH:  timing.enable_high_ticks = data[9:0];
            CFG_NIBBLE_GAP:   timing.nibble_gap_ticks = data[9:0];
            CFG_BYTE_SETTLE:  timing.byte_settle_ticks = data[9:0];
            CFG_CLEAR_WAIT:   timing.clear_wait_ticks = data[15:0];
            CFG_POWERUP_WAIT: timing.powerup_wait_ticks = data[16:0];
            CFG_INIT_GAP:     timing.init_gap_ticks = data[9:0];
            default: ;
        endcase
    endfunction

    function automatic void reset_model();
        timing.enable_high_ticks = 10'd10;
        timing.nibble_gap_ticks = 10'd1;
        timing.byte_settle_ticks = 10'd40;
        timing.clear_wait_ticks = 16'd2000;
        timing.powerup_wait_ticks = 17'd100000;
        timing.init_gap_ticks = 10'd100;
        lcd_port = 8'h00;
        seq = SEQ_IDLE;
        remaining = 64'd0;
        held_byte = 8'h00;
        held_sel = 1'b0;
        init_step = 4'd0;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            reset_model();
            port_image_q.delete();
        end else begin
            if (i_cfg_we) apply_setting(i_cfg_idx, i_cfg_data);
            if (i_in_valid && i_in_ready)
                port_image_q.push_back(advance_sequencer(i_req_type, i_byte_value,
                                                         i_reg_select));
            if (i_out_valid && i_out_ready) begin
                if (port_image_q.size() == 0) begin
                    report_mismatch("unexpected result beat", i_port_value, 8'h00);
                end else begin
                    want = port_image_q.pop_front();
                    if (i_port_value !== want.port_value)
                        report_mismatch("port_value", i_port_value, want.port_value);
                    if (i_busy_res !== want.busy_res)
                        report_mismatch("busy_res", 8'(i_busy_res), 8'(want.busy_res));
                    if (i_accepted !== want.accepted)
                        report_mismatch("accepted", 8'(i_accepted), 8'(want.accepted));
                end
            end
        end
        o_outstanding <= port_image_q.size();
        o_seq_busy <= (seq != SEQ_IDLE);
    end

endmodule

### verif/testbench.sv
// testbench top: clock, reset, requests and timing setup around the lcd sequencer
`timescale 1ns / 100ps
module testbench;
    import lcdnb_pkg::*;

    localparam logic [1:0] REQ_RESERVED  = 2'd3;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         RANDOM_BEATS  = 700;
    localparam int         RANDOM_PHASES = 6;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [1:0]            i_req_type;
    logic [7:0]            i_byte_value;
    logic                  i_reg_select;
    logic                  o_valid;
    logic                  i_ready;
    logic [7:0]            o_port_value;
    logic                  o_busy_res;
    logic                  o_accepted;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int   mismatches;
    int   outstanding;
    logic seq_busy;
    bit   no_gaps;
    int   cycles = 0;

    char_lcd_nibble_bus_sequencer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_byte_value (i_byte_value),
        .i_reg_select (i_reg_select),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_port_value (o_port_value),
        .o_busy_res   (o_busy_res),
        .o_accepted   (o_accepted),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    lcdnb_checker port_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_req_type    (i_req_type),
        .i_byte_value  (i_byte_value),
        .i_reg_select  (i_reg_select),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_port_value  (o_port_value),
        .i_busy_res    (o_busy_res),
        .i_accepted    (o_accepted),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_seq_busy    (seq_busy)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) i_ready <= no_gaps || ($urandom_range(0, 99) >= 27);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[char_lcd_nibble_bus_sequencer] ERROR");
            $finish;
        end
    end

    task automatic issue_request(input logic [1:0] kind, input logic [7:0] value,
                                 input logic sel);
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(0, 99) < 27) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= kind;
        i_byte_value <= value;
        i_reg_select <= sel;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // busy flag lags one beat, so the tick after it reads idle lands on an idle block
    task automatic run_out();
        do issue_request(REQ_TICK, 8'($urandom), 1'($urandom));
        while (seq_busy);
    endtask

    task automatic settle_block();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_timing(input logic [16:0] en_high, input logic [16:0] nib_gap,
                              input logic [16:0] settle, input logic [16:0] clr_wait,
                              input logic [16:0] pwr_wait, input logic [16:0] init_gap);
        write_reg(CFG_ENABLE_HIGH, en_high);
        write_reg(CFG_NIBBLE_GAP, nib_gap);
        write_reg(CFG_BYTE_SETTLE, settle);
        write_reg(CFG_CLEAR_WAIT, clr_wait);
        write_reg(CFG_POWERUP_WAIT, pwr_wait);
        write_reg(CFG_INIT_GAP, init_gap);
    endtask

    task automatic random_item(output bit counted);
        int         roll;
        logic [1:0] kind;
        logic [7:0] value;
        logic       sel;
        roll = $urandom_range(0, 99);
        value = 8'($urandom);
        sel = 1'($urandom);
        if (!seq_busy) begin
            if (roll < 55) kind = REQ_WRITE;
            else if (roll < 70) kind = REQ_INIT;
            else if (roll < 90) kind = REQ_TICK;
            else kind = REQ_RESERVED;
        end else begin
            if (roll < 86) kind = REQ_TICK;
            else if (roll < 92) kind = REQ_WRITE;
            else if (roll < 97) kind = REQ_INIT;
            else kind = REQ_RESERVED;
        end
        if (kind == REQ_WRITE && $urandom_range(0, 99) < 15) begin
            value = CMD_CLEAR;
            sel = 1'b0;
        end
        issue_request(kind, value, sel);
        counted = (kind != REQ_RESERVED);
    endtask

    initial begin : stimulus
        int sent;
        bit counted;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req_type = REQ_TICK;
        i_byte_value = 8'h00;
        i_reg_select = 1'b0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ENABLE_HIGH;
        i_cfg_data = '0;
        no_gaps = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset timing: idle tick, reserved code, write before init, refused requests
        issue_request(REQ_TICK, 8'h00, 1'b0);
        issue_request(REQ_RESERVED, 8'hFF, 1'b1);
        issue_request(REQ_WRITE, 8'hFF, 1'b1);
        issue_request(REQ_WRITE, 8'h00, 1'b0);
        issue_request(REQ_INIT, 8'h55, 1'b1);
        run_out();
        settle_block();

        set_timing(17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1);
        issue_request(REQ_INIT, 8'h00, 1'b0);
        issue_request(REQ_WRITE, 8'hAA, 1'b1);
        issue_request(REQ_RESERVED, 8'h00, 1'b0);
        run_out();
        issue_request(REQ_WRITE, CMD_CLEAR, 1'b0);
        run_out();
        issue_request(REQ_WRITE, 8'h00, 1'b0);
        run_out();
        issue_request(REQ_WRITE, 8'h80, 1'b1);
        run_out();
        settle_block();

        // zero loads expire on the next tick
        set_timing(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0);
        issue_request(REQ_INIT, 8'hFF, 1'b1);
        run_out();
        issue_request(REQ_WRITE, CMD_CLEAR, 1'b0);
        run_out();
        issue_request(REQ_WRITE, 8'h5A, 1'b1);
        run_out();
        issue_request(REQ_RESERVED, 8'h00, 1'b1);
        settle_block();

        // bits above a register's width are dropped
        set_timing(17'h1FC03, 17'h1FC02, 17'h1FC04, 17'h10005, 17'h1FC03, 17'h1FC02);
        issue_request(REQ_WRITE, 8'hC3, 1'b0);
        run_out();
        issue_request(REQ_WRITE, CMD_CLEAR, 1'b0);
        run_out();
        settle_block();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_timing(17'($urandom_range(0, 6)), 17'($urandom_range(0, 6)),
                       17'($urandom_range(0, 12)), 17'($urandom_range(0, 20)),
                       17'($urandom_range(0, 25)), 17'($urandom_range(0, 10)));
            no_gaps = (p == 2);
            sent = 0;
            while (sent < RANDOM_BEATS / RANDOM_PHASES) begin
                random_item(counted);
                if (counted) sent++;
            end
            run_out();
            settle_block();
        end
        no_gaps = 1'b0;
        repeat (8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[char_lcd_nibble_bus_sequencer] OK");
        end else begin
            $display("[char_lcd_nibble_bus_sequencer] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
src/lcdnb_pkg.sv
src/lcdnb_cfg.sv
src/lcdnb_core.sv
src/char_lcd_nibble_bus_sequencer.sv
verif/lcdnb_checker.sv
verif/testbench.sv
